// File: rtl/core/mvsl_pkg.sv
// mvsl_pkg: field widths, decision codes and fixed constants of the
// motion velocity safety limiter. No dependencies.

package mvsl_pkg;

   localparam int RpmW = 16;
   localparam int PosW = 32;
   localparam int MaxRpmW = 15;
   localparam int TimeW = 16;
   localparam int DecW = 2;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 32;

   // milliseconds per minute, factor on the distance side of the time test
   localparam int MsPerMin = 60000;
   localparam int MsPerMinW = 16;

   localparam logic [DecW-1:0] DEC_PASS = 2'd0;
   localparam logic [DecW-1:0] DEC_LIMIT = 2'd1;
   localparam logic [DecW-1:0] DEC_TIME = 2'd2;
   localparam logic [DecW-1:0] DEC_CLAMP = 2'd3;

   localparam logic [CsrIdxW-1:0] CSR_UPPER = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_LOWER = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_MAX_RPM = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_TIME = 2'd3;

   typedef logic signed [RpmW-1:0] rpm_type;
   typedef logic [DecW-1:0] dec_type;

endpackage

// File: rtl/core/motion_velocity_safety_limiter.sv
// motion_velocity_safety_limiter: top level, four register stages that check a
// velocity request against joint position limits and remaining travel time.
// Depends on mvsl_pkg.
//
// a request is registered in s1, s2, s3 and s4 in order; rsp_tvalid is the valid bit of s4
// throughput: one request per cycle while rsp_tready holds high; each stage
//   holds its item and valid bit, and refills in the cycle its item moves on
// reset (synchronous, active high) clears all stage valid bits and the four
//   configuration registers to zero

module motion_velocity_safety_limiter
   import mvsl_pkg::*;
#(
   parameter int ENC_LINES = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [47:0]         req_tdata,   // [15:0] requested_rpm, [47:16] encoder_position
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,   // [15:0] command_rpm, [17:16] decision, rest zero
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   // pulses per motor revolution (quadrature)
   localparam int PulsesPerRev = 4 * ENC_LINES;
   localparam int PprW = $clog2(PulsesPerRev + 1);
   localparam int DistW = PosW;
   localparam int DistProdW = DistW + MsPerMinW;
   localparam int TmProdW = TimeW + RpmW;
   localparam int LimProdW = TmProdW + PprW;
   localparam int CmpW = (DistProdW > LimProdW) ? DistProdW : LimProdW;

   // configuration
   logic signed [PosW-1:0] upper_ff;
   logic signed [PosW-1:0] lower_ff;
   logic [MaxRpmW-1:0]     max_rpm_ff;
   logic [TimeW-1:0]       time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff   <= '0;
         lower_ff   <= '0;
         max_rpm_ff <= '0;
         time_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_UPPER:   upper_ff   <= csr_wdata[PosW-1:0];
            CSR_LOWER:   lower_ff   <= csr_wdata[PosW-1:0];
            CSR_MAX_RPM: max_rpm_ff <= csr_wdata[MaxRpmW-1:0];
            CSR_TIME:    time_ff    <= csr_wdata[TimeW-1:0];
            default: ;
         endcase
      end
   end

   // stage advance chain
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv1, adv2, adv3, adv4;

   assign adv4 = !v4_ff || rsp_tready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_tready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= req_tvalid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
         if (adv4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   // stage 1: limit checks and distance toward the limit in the travel direction
   rpm_type                req_rpm;
   logic signed [PosW-1:0] req_pos;
   logic                   rpm_pos, rpm_neg;
   logic signed [PosW:0]   diff_up, diff_lo;
   logic                   early_in;
   dec_type                early_dec_in;
   logic [DistW-1:0]       dist_in;
   logic [RpmW-1:0]        mag_in;

   assign req_rpm = req_tdata[RpmW-1:0];
   assign req_pos = req_tdata[RpmW+PosW-1:RpmW];
   assign rpm_pos = !req_rpm[RpmW-1] && (req_rpm != '0);
   assign rpm_neg = req_rpm[RpmW-1];
   assign diff_up = {upper_ff[PosW-1], upper_ff} - {req_pos[PosW-1], req_pos};
   assign diff_lo = {req_pos[PosW-1], req_pos} - {lower_ff[PosW-1], lower_ff};

   always_comb begin
      early_in     = 1'b0;
      early_dec_in = DEC_PASS;
      dist_in      = '0;
      if (req_rpm == '0) begin
         early_in = 1'b1;
      end else if ((rpm_pos && (req_pos > upper_ff)) || (rpm_neg && (req_pos < lower_ff))) begin
         early_in     = 1'b1;
         early_dec_in = DEC_LIMIT;
      end
      if (rpm_pos && (req_pos < upper_ff)) begin
         dist_in = diff_up[DistW-1:0];
      end else if (rpm_neg && (req_pos > lower_ff)) begin
         dist_in = diff_lo[DistW-1:0];
      end
      mag_in = rpm_neg ? (RpmW'(0) - req_rpm) : req_rpm;
   end

   rpm_type          s1_rpm_ff;
   logic             s1_early_ff;
   dec_type          s1_dec_ff;
   logic [DistW-1:0] s1_dist_ff;
   logic [RpmW-1:0]  s1_mag_ff;

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_rpm_ff   <= req_rpm;
         s1_early_ff <= early_in;
         s1_dec_ff   <= early_dec_in;
         s1_dist_ff  <= dist_in;
         s1_mag_ff   <= mag_in;
      end
   end

   // stage 2: distance times ms per minute, time limit times speed
   logic [DistProdW-1:0] dist_prod_in;
   logic [TmProdW-1:0]   tm_prod_in;

   assign dist_prod_in = DistProdW'(s1_dist_ff) * DistProdW'(MsPerMin);
   assign tm_prod_in   = TmProdW'(time_ff) * TmProdW'(s1_mag_ff);

   rpm_type              s2_rpm_ff;
   logic                 s2_early_ff;
   dec_type              s2_dec_ff;
   logic [DistProdW-1:0] s2_dist_ff;
   logic [TmProdW-1:0]   s2_tm_ff;

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_rpm_ff   <= s1_rpm_ff;
         s2_early_ff <= s1_early_ff;
         s2_dec_ff   <= s1_dec_ff;
         s2_dist_ff  <= dist_prod_in;
         s2_tm_ff    <= tm_prod_in;
      end
   end

   // stage 3: scale by pulses per revolution
   logic [LimProdW-1:0] lim_prod_in;

   assign lim_prod_in = LimProdW'(s2_tm_ff) * LimProdW'(PulsesPerRev);

   rpm_type              s3_rpm_ff;
   logic                 s3_early_ff;
   dec_type              s3_dec_ff;
   logic [DistProdW-1:0] s3_dist_ff;
   logic [LimProdW-1:0]  s3_lim_ff;

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_rpm_ff   <= s2_rpm_ff;
         s3_early_ff <= s2_early_ff;
         s3_dec_ff   <= s2_dec_ff;
         s3_dist_ff  <= s2_dist_ff;
         s3_lim_ff   <= lim_prod_in;
      end
   end

   // stage 4: time test and symmetric clamp
   logic signed [RpmW:0] rpm_ext, max_ext;
   rpm_type              cmd_in;
   dec_type              dec_in;

   assign rpm_ext = {s3_rpm_ff[RpmW-1], s3_rpm_ff};
   assign max_ext = (RpmW+1)'(max_rpm_ff);

   always_comb begin
      cmd_in = '0;
      dec_in = s3_dec_ff;
      if (!s3_early_ff) begin
         if (CmpW'(s3_dist_ff) <= CmpW'(s3_lim_ff)) begin
            dec_in = DEC_TIME;
         end else if (rpm_ext > max_ext) begin
            cmd_in = RpmW'(max_rpm_ff);
            dec_in = DEC_CLAMP;
         end else if (rpm_ext < -max_ext) begin
            cmd_in = RpmW'(0) - RpmW'(max_rpm_ff);
            dec_in = DEC_CLAMP;
         end else begin
            cmd_in = s3_rpm_ff;
            dec_in = DEC_PASS;
         end
      end
   end

   rpm_type s4_cmd_ff;
   dec_type s4_dec_ff;

   always_ff @(posedge clock) begin
      if (adv4) begin
         s4_cmd_ff <= cmd_in;
         s4_dec_ff <= dec_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {6'd0, s4_dec_ff, s4_cmd_ff};

   // a zeroing decision never lets a nonzero command through
   a_zero_on_stop : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (s4_dec_ff == DEC_LIMIT || s4_dec_ff == DEC_TIME) |-> s4_cmd_ff == '0)
      else $error("nonzero command with a stopping decision");

   // a clamped command sits exactly at the configured magnitude
   a_clamp_mag : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && s4_dec_ff == DEC_CLAMP |->
         (s4_cmd_ff == RpmW'(max_rpm_ff)) || (s4_cmd_ff == RpmW'(0) - RpmW'(max_rpm_ff)))
      else $error("clamped command off the limit magnitude");

   // a stalled stage keeps its item until the next stage takes it
   a_stage3_hold : assert property (@(posedge clock) disable iff (reset)
      v3_ff && !adv4 && v4_ff |=> v3_ff && $stable(s3_rpm_ff) && $stable(s3_dist_ff))
      else $error("stage 3 item lost during stall");

   // reset empties the pipeline
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !v1_ff && !v2_ff && !v3_ff && !v4_ff)
      else $error("pipeline not empty after reset");

endmodule

// File: test/motion_velocity_safety_limiter_tb.sv
// motion_velocity_safety_limiter_tb: self-checking testbench for the velocity limiter.
// Runs directed limit cases, a long output stall and random traffic, and checks every
// response against an in-bench model of the limiter. Depends on mvsl_pkg and the RTL.

module motion_velocity_safety_limiter_tb;
   import mvsl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int EncLines = 512;
   localparam longint MsPerMinute = 60000;
   localparam int Latency = 4;
   localparam int HoldCycles = 300;
   localparam int WatchdogLimit = 2000;
   localparam int IdlePercent = 12;

   typedef logic signed [PosW-1:0] position_type;

   typedef struct packed {
      rpm_type command;
      dec_type decision;
   } verdict_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [47:0]         req_tdata = '0;    // [15:0] requested_rpm, [47:16] encoder_position
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [23:0]         rsp_tdata;         // [15:0] command_rpm, [17:16] decision, rest zero
   logic                csr_we = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   // copy of the limiter settings
   position_type        lim_upper = '0;
   position_type        lim_lower = '0;
   logic [MaxRpmW-1:0]  lim_max_rpm = '0;
   logic [TimeW-1:0]    lim_time = '0;

   verdict_type         pending_verdicts[$];
   int                  mismatches = 0;
   int                  quiet_cycles = 0;
   bit                  idle_en = 1'b1;
   bit                  hold_request = 1'b0;
   int                  hold_left = 0;

   motion_velocity_safety_limiter #(
      .ENC_LINES(EncLines)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected command and reason for one request under the current settings
   function automatic verdict_type guard_velocity(rpm_type rpm, position_type pos);
      verdict_type v;
      longint r, p, up, lo, mag, room, mx;
      r = rpm;
      p = pos;
      up = lim_upper;
      lo = lim_lower;
      mx = longint'(lim_max_rpm);
      v.command = '0;
      v.decision = DEC_PASS;
      if (r == 0) begin
         v.decision = DEC_PASS;
      end else if ((r > 0 && p > up) || (r < 0 && p < lo)) begin
         v.decision = DEC_LIMIT;
      end else begin
         mag = (r < 0) ? -r : r;
         room = 0;
         if (r > 0 && p < up) begin
            room = up - p;
         end else if (r < 0 && p > lo) begin
            room = p - lo;
         end
         if (room * MsPerMinute <= longint'(lim_time) * mag * (4 * EncLines)) begin
            v.decision = DEC_TIME;
         end else if (r > mx) begin
            v.command = mx[15:0];
            v.decision = DEC_CLAMP;
         end else if (r < -mx) begin
            mx = -mx;
            v.command = mx[15:0];
            v.decision = DEC_CLAMP;
         end else begin
            v.command = rpm;
         end
      end
      return v;
   endfunction

   // response side: random idling, plus a long hold-off when asked for
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HoldCycles;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idle_en && $urandom_range(99) < IdlePercent);
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            $error("response with none expected: rsp_tdata %h", rsp_tdata);
            mismatches++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tdata[15:0] !== want.command) begin
               $error("command_rpm expected %0d actual %0d",
                      $signed(want.command), $signed(rsp_tdata[15:0]));
               mismatches++;
            end
            if (rsp_tdata[17:16] !== want.decision) begin
               $error("decision expected %0d actual %0d", want.decision, rsp_tdata[17:16]);
               mismatches++;
            end
            if (rsp_tdata[23:18] !== '0) begin
               $error("rsp_tdata padding expected 0 actual %h", rsp_tdata[23:18]);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // valid stays high between back-to-back requests, dropped on idle cycles and by drain_responses
   task automatic send_request(rpm_type rpm, position_type pos);
      while (idle_en && $urandom_range(99) < IdlePercent) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {pos, rpm};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_verdicts.push_back(guard_velocity(rpm, pos));
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (Latency + 2) @(posedge clock);
   endtask

   // writes all four registers back to back; upper bits of the narrow ones carry noise
   task automatic load_settings(position_type up, position_type lo,
                                logic [MaxRpmW-1:0] mx, logic [TimeW-1:0] tl);
      logic [31:0] noise;
      noise = $urandom;
      csr_we <= 1'b1;
      csr_index <= CSR_UPPER;
      csr_wdata <= up;
      @(posedge clock);
      csr_index <= CSR_LOWER;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_MAX_RPM;
      csr_wdata <= {noise[31:15], mx};
      @(posedge clock);
      csr_index <= CSR_TIME;
      csr_wdata <= {noise[31:16], tl};
      @(posedge clock);
      csr_we <= 1'b0;
      lim_upper = up;
      lim_lower = lo;
      lim_max_rpm = mx;
      lim_time = tl;
   endtask

   task automatic load_random_settings();
      logic [31:0] center, span;
      logic [TimeW-1:0] tl;
      center = $urandom;
      span = $urandom_range(0, 32'(1) << $urandom_range(0, 24));
      case ($urandom_range(3))
         0: tl = 16'd0;
         1: tl = 16'hffff;
         2: tl = 16'($urandom_range(1, 2000));
         default: tl = 16'($urandom);
      endcase
      if ($urandom_range(9) == 0) begin
         load_settings(center - span, center + span, 15'($urandom), tl);
      end else begin
         load_settings(center + span, center - span, 15'($urandom), tl);
      end
   endtask

   function automatic rpm_type pick_rpm();
      int top, mag;
      top = 2 * int'(lim_max_rpm) + 16;
      if (top > 32767) top = 32767;
      mag = $urandom_range(1, top);
      case ($urandom_range(9))
         0: return '0;
         1: return 16'sh7fff;
         2: return 16'sh8000;
         3, 4: return rpm_type'($urandom);
         default: return ($urandom_range(1) == 1) ? rpm_type'(mag) : rpm_type'(-mag);
      endcase
   endfunction

   // positions cluster around the limits, scaled to straddle the time threshold
   function automatic position_type pick_position(rpm_type rpm);
      longint base, off, mag, thr;
      mag = (rpm < 0) ? -longint'(rpm) : longint'(rpm);
      thr = longint'(lim_time) * mag * (4 * EncLines) / MsPerMinute;
      case ($urandom_range(7))
         0: return position_type'($urandom);
         1: base = lim_lower;
         2: base = lim_upper;
         3, 4, 5: base = (rpm < 0) ? longint'(lim_lower) : longint'(lim_upper);
         default: base = (longint'(lim_lower) + longint'(lim_upper)) / 2;
      endcase
      case ($urandom_range(3))
         0: off = $urandom_range(0, 2);
         1: off = $urandom_range(0, 32'(1) << $urandom_range(0, 30));
         default: off = $urandom_range(0, 32'(2 * thr + 2));
      endcase
      if ($urandom_range(1) == 1) off = -off;
      base = base + off;
      return base[31:0];
   endfunction

   // all registers are zero out of reset
   task automatic test_reset_state();
      send_request(16'sd5, 32'sd0);
      send_request(16'sd5, 32'sd3);
      send_request(-16'sd5, 32'sd3);
      drain_responses();
   endtask

   task automatic test_limit_cases();
      load_settings(32'sd1000, -32'sd1000, 15'd3000, 16'd1875);
      send_request(16'sd0, 32'sh7fffffff);
      send_request(16'sd0, 32'sh80000000);
      send_request(16'sd100, 32'sd1000);
      send_request(-16'sd100, -32'sd1000);
      send_request(16'sd100, 32'sd1001);
      send_request(-16'sd100, -32'sd1001);
      send_request(-16'sd100, 32'sh7fffffff);
      send_request(16'sh7fff, 32'sh80000000);
      send_request(16'sh8000, 32'sh7fffffff);
      // 64 pulses at 1 rpm and 1875 ms lands exactly on the time threshold
      send_request(16'sd1, 32'sd936);
      send_request(16'sd1, 32'sd935);
      drain_responses();
   endtask

   task automatic test_swapped_limits();
      load_settings(-32'sd500, 32'sd500, 15'd0, 16'd1);
      send_request(-16'sd7, 32'sd500);
      send_request(16'sd7, -32'sd500);
      send_request(16'sd1, 32'sd0);
      send_request(-16'sd1, 32'sd0);
      drain_responses();
   endtask

   task automatic test_zero_time_limit();
      load_settings(32'sd10, -32'sd10, 15'h7fff, 16'd0);
      send_request(16'sd5, 32'sd9);
      send_request(16'sd5, 32'sd10);
      send_request(16'sh8000, 32'sd0);
      send_request(16'sh7fff, 32'sd0);
      drain_responses();
   endtask

   task automatic test_extreme_limits();
      load_settings(32'sh7fffffff, 32'sh80000000, 15'h7fff, 16'hffff);
      send_request(16'sd1, 32'sh80000000);
      send_request(16'sh8000, 32'sh80000000);
      send_request(16'sh7fff, 32'sd2147483000);
      drain_responses();
   endtask

   // output held off long enough that the pipeline fills and stalls its input
   task automatic test_output_stall();
      rpm_type rpm;
      load_random_settings();
      hold_request = 1'b1;
      repeat (40) begin
         rpm = pick_rpm();
         send_request(rpm, pick_position(rpm));
      end
      drain_responses();
   endtask

   task automatic test_random_traffic();
      rpm_type rpm;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: load_settings(32'sh7fffffff, 32'sh80000000, 15'h7fff, 16'hffff);
            1: load_settings(32'sh80000000, 32'sh7fffffff, 15'd0, 16'd0);
            default: load_random_settings();
         endcase
         idle_en = (ph != 3);
         repeat (200) begin
            rpm = pick_rpm();
            send_request(rpm, pick_position(rpm));
         end
         drain_responses();
      end
      idle_en = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_limit_cases();
      test_swapped_limits();
      test_zero_time_limit();
      test_extreme_limits();
      test_output_stall();
      test_random_traffic();
      drain_responses();
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
